// ===== hw/rtl/svp_pkg.sv =====
`default_nettype none
package svp_pkg;

  localparam int DIMS_DEFAULT = 2;

  // exp(-x) unit shape
  localparam int EXP_NBITS = 6;
  localparam int EXP_TERMS = 13;
  localparam int EXP_LAT   = 2 + EXP_NBITS + 2 * EXP_TERMS;

  // divider shape: one quotient bit per stage plus the load stage
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  // lane front end, merge, link prep, divider feed, polynomial, tail, output
  localparam int LANE_FRONT = 3;
  localparam int SVP_LAT = LANE_FRONT + EXP_LAT + 3 + EXP_LAT + DIV_LAT + 7;

  localparam logic [31:0] LN2_Q32         = 32'd2977044471;
  localparam logic [63:0] EXP_LIMIT       = 64'd98242467543; // 33 * ln2 in Q.32
  localparam logic [31:0] AS_P_Q32        = 32'd994894385;
  localparam logic [31:0] INV_SQRT2PI_Q32 = 32'd1713444047;
  localparam logic [33:0] ONE_Q32         = 34'h1_0000_0000;

  localparam logic signed [36:0] AS_B1 = 37'sd1371733226;
  localparam logic signed [36:0] AS_B2 = -37'sd1531429782;
  localparam logic signed [36:0] AS_B3 = 37'sd7651389478;
  localparam logic signed [36:0] AS_B4 = -37'sd7822234863;
  localparam logic signed [36:0] AS_B5 = 37'sd5713485167;

  // Horner constants added after each product, last step adds nothing
  localparam logic signed [36:0] POLY_C [0:4] = '{AS_B4, AS_B3, AS_B2, AS_B1, 37'sd0};

  localparam logic [7:0] REG_BETA   = 8'd0;
  localparam logic [7:0] REG_W_ZERO = 8'd1;
  localparam logic [7:0] REG_W_ONE  = 8'd2;
  localparam logic [7:0] REG_MODE   = 8'd3;

  typedef struct packed {
    logic [15:0] beta;
    logic [15:0] w_zero;
    logic [15:0] w_one;
    logic        mode;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{beta: 16'd2048, w_zero: 16'd4096,
                                      w_one: 16'd4096, mode: 1'b1};

endpackage
`default_nettype wire

// ===== hw/rtl/svp_exp.sv =====
`default_nettype none
module svp_exp import svp_pkg::*; #(
  parameter int XW    = 40,
  parameter int SideW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [XW-1:0]    x,
  input  logic [SideW-1:0] in_side,
  output logic             out_valid,
  output logic [32:0]      y,
  output logic [SideW-1:0] out_side
);

  localparam int NB = EXP_NBITS;
  localparam int TS = 2 * EXP_TERMS;

  typedef struct packed {
    logic             z;
    logic [NB-1:0]    n;
    logic [36:0]      rem;
    logic [SideW-1:0] side;
  } red_t;

  typedef struct packed {
    logic               z;
    logic [NB-1:0]      n;
    logic [31:0]        r;
    logic signed [34:0] sum;
    logic [32:0]        term;
    logic [SideW-1:0]   side;
  } term_t;

  red_t  red [0:NB];
  logic  rv  [0:NB];
  term_t ts  [0:TS];
  logic  tv  [0:TS];
  logic [32:0] pos;

  // flag arguments past 33*ln2, where the result is zero
  always_ff @(posedge clk) begin
    if (rst) rv[0] <= 1'b0;
    else rv[0] <= in_valid;
    red[0].z    <= (x >= XW'(EXP_LIMIT));
    red[0].n    <= '0;
    red[0].rem  <= x[36:0];
    red[0].side <= in_side;
  end

  // range reduction: one bit of n per stage
  for (genvar j = 0; j < NB; j++) begin : g_red
    localparam int B = NB - 1 - j;
    localparam logic [36:0] SUBV = 37'(LN2_Q32) << B;
    always_ff @(posedge clk) begin
      if (rst) rv[j+1] <= 1'b0;
      else rv[j+1] <= rv[j];
      red[j+1] <= red[j];
      if (red[j].rem >= SUBV) begin
        red[j+1].rem  <= red[j].rem - SUBV;
        red[j+1].n[B] <= 1'b1;
      end
    end
  end

  always_comb begin
    ts[0].z    = red[NB].z;
    ts[0].n    = red[NB].n;
    ts[0].r    = red[NB].rem[31:0];
    ts[0].sum  = 35'sh1_0000_0000;
    ts[0].term = 33'h1_0000_0000;
    ts[0].side = red[NB].side;
    tv[0]      = rv[NB];
  end

  // Taylor series: multiply by r, then divide by k through a reciprocal
  for (genvar i = 0; i < TS; i++) begin : g_term
    if (i % 2 == 0) begin : g_mul
      logic [64:0] prod;
      assign prod = 65'(ts[i].term) * 65'(ts[i].r);
      always_ff @(posedge clk) begin
        if (rst) tv[i+1] <= 1'b0;
        else tv[i+1] <= tv[i];
        ts[i+1]      <= ts[i];
        ts[i+1].term <= prod[64:32];
      end
    end else begin : g_div
      localparam int K = i / 2 + 1;
      localparam int L = $clog2(K);
      localparam int S = 32 + L;
      localparam logic [33:0] M = 34'(((67'd1 << S) + 67'(K) - 67'd1) / 67'(K));
      logic [66:0] prod;
      logic [32:0] q;
      assign prod = 67'(ts[i].term) * 67'(M);
      assign q    = 33'(prod >> S);
      always_ff @(posedge clk) begin
        if (rst) tv[i+1] <= 1'b0;
        else tv[i+1] <= tv[i];
        ts[i+1]      <= ts[i];
        ts[i+1].term <= q;
        if (K % 2 == 1) ts[i+1].sum <= ts[i].sum - 35'(q);
        else ts[i+1].sum <= ts[i].sum + 35'(q);
      end
    end
  end

  // clamp a negative sum at zero
  assign pos = ts[TS].sum[34] ? 33'd0 : ts[TS].sum[32:0];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= tv[TS];
    y        <= ts[TS].z ? 33'd0 : (pos >> ts[TS].n);
    out_side <= ts[TS].side;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/svp_div.sv =====
`default_nettype none
module svp_div import svp_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [63:0]      num,
  input  logic [33:0]      den,
  input  logic [SideW-1:0] in_side,
  output logic             out_valid,
  output logic [31:0]      q,
  output logic [SideW-1:0] out_side
);

  // quotient must fit 32 bits: num[63:32] < den
  typedef struct packed {
    logic [33:0]      rem;
    logic [31:0]      low;
    logic [31:0]      q;
    logic [33:0]      den;
    logic [SideW-1:0] side;
  } div_t;

  div_t st [0:DIV_STEPS];
  logic sv [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else sv[0] <= in_valid;
    st[0].rem  <= {2'b00, num[63:32]};
    st[0].low  <= num[31:0];
    st[0].q    <= '0;
    st[0].den  <= den;
    st[0].side <= in_side;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [34:0] t;
    assign t = {st[j].rem, st[j].low[31]};
    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else sv[j+1] <= sv[j];
      st[j+1]     <= st[j];
      st[j+1].low <= {st[j].low[30:0], 1'b0};
      if (t >= {1'b0, st[j].den}) begin
        st[j+1].rem <= 34'(t - {1'b0, st[j].den});
        st[j+1].q   <= {st[j].q[30:0], 1'b1};
      end else begin
        st[j+1].rem <= t[33:0];
        st[j+1].q   <= {st[j].q[30:0], 1'b0};
      end
    end
  end

  assign out_valid = sv[DIV_STEPS];
  assign q         = st[DIV_STEPS].q;
  assign out_side  = st[DIV_STEPS].side;

endmodule
`default_nettype wire

// ===== hw/rtl/svp_lane.sv =====
`default_nettype none
module svp_lane import svp_pkg::*; #(
  parameter int Dims = DIMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] ideal_zero,
  input  logic signed [15:0] ideal_one,
  input  logic signed [15:0] pos_zero,
  input  logic signed [15:0] pos_one,
  input  cfg_regs_t          cfg,
  output logic               out_valid,
  output logic [32:0]        util
);

  localparam int USED = (Dims < 2) ? Dims : 2;

  logic signed [16:0] d0;
  logic [15:0] m0;
  logic [31:0] sq0;
  logic [47:0] wd0;
  logic [47:0] wd1;
  logic        v1, v2, v3;
  logic [48:0] dsum;

  assign d0 = 17'(ideal_zero) - 17'(pos_zero);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    m0  <= d0[16] ? 16'(-d0) : d0[15:0];
    sq0 <= 32'(m0) * 32'(m0);
    wd0 <= 48'(sq0) * 48'(cfg.w_zero);
  end

  if (USED == 2) begin : g_dim1
    logic signed [16:0] d1;
    logic [15:0] m1;
    logic [31:0] sq1;
    assign d1 = 17'(ideal_one) - 17'(pos_one);
    always_ff @(posedge clk) begin
      m1  <= d1[16] ? 16'(-d1) : d1[15:0];
      sq1 <= 32'(m1) * 32'(m1);
      wd1 <= 48'(sq1) * 48'(cfg.w_one);
    end
  end else begin : g_no_dim1
    assign wd1 = '0;
  end

  // drop four fraction bits: Q.36 to Q.32
  assign dsum = 49'(wd0) + 49'(wd1);

  svp_exp #(.XW(45), .SideW(1)) u_exp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .x        (dsum[48:4]),
    .in_side  (1'b0),
    .out_valid(out_valid),
    .y        (util),
    .out_side ()
  );

endmodule
`default_nettype wire

// ===== hw/rtl/spatial_vote_probability_unit.sv =====
// Channel   | Signals                                    | Handshake
// --------- | ------------------------------------------ | -----------------------------
// input     | start, busy, ideal/yea/nay_pos_zero/one     | taken when start && !busy
// result    | done, yea_probability                       | one-cycle strobe, no stall
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data   | write when valid && ready
//
// One transaction per cycle; the result path runs through the two exp units in series
// (34 stages each), the 33-stage bit-per-stage divider and the five-stage Horner
// polynomial, besides the lane front end, merge, tail and output registers.
// busy is high only during reset; cfg_ready is always high.
// rst is synchronous: it clears every valid bit and loads the register resets.
`default_nettype none
module spatial_vote_probability_unit import svp_pkg::*; #(
  parameter int Dims = DIMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] ideal_pos_zero,
  input  logic signed [15:0] ideal_pos_one,
  input  logic signed [15:0] yea_pos_zero,
  input  logic signed [15:0] yea_pos_one,
  input  logic signed [15:0] nay_pos_zero,
  input  logic signed [15:0] nay_pos_one,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic [15:0]        yea_probability
);

  cfg_regs_t cfg;
  logic        accept;
  logic        yv, nv;
  logic [32:0] uy, un;

  logic               k1v, k2v, k3v;
  logic signed [33:0] diff;
  logic signed [50:0] zprod;
  logic [39:0]        ax;
  logic               neg2;
  logic [39:0]        ein;
  logic [34:0]        side3;
  logic [34:0]        x35;
  logic [69:0]        sqp;
  logic [64:0]        pxp;
  logic               big;

  logic        ev;
  logic [32:0] e;
  logic [34:0] eside;
  logic [48:0] lnum;
  logic [33:0] lden;
  logic [63:0] dnum;
  logic [33:0] dden;
  logic [63:0] phip;

  logic        dv;
  logic [31:0] dq;
  logic [33:0] dside;

  logic signed [36:0] pa [0:5];
  logic [31:0] pt   [0:5];
  logic        pneg [0:5];
  logic        pbig [0:5];
  logic [31:0] pphi [0:5];
  logic        pv   [0:5];

  logic [35:0] accp;
  logic [66:0] tprod;
  logic [32:0] tail;
  logic        v6, neg6;
  logic [31:0] q6;
  logic [32:0] nval;
  logic [17:0] nround;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BETA:   cfg.beta   <= cfg_data;
        REG_W_ZERO: cfg.w_zero <= cfg_data;
        REG_W_ONE:  cfg.w_one  <= cfg_data;
        REG_MODE:   cfg.mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  svp_lane #(.Dims(Dims)) u_lane_yea (
    .clk(clk), .rst(rst), .in_valid(accept),
    .ideal_zero(ideal_pos_zero), .ideal_one(ideal_pos_one),
    .pos_zero(yea_pos_zero), .pos_one(yea_pos_one),
    .cfg(cfg), .out_valid(yv), .util(uy)
  );

  svp_lane #(.Dims(Dims)) u_lane_nay (
    .clk(clk), .rst(rst), .in_valid(accept),
    .ideal_zero(ideal_pos_zero), .ideal_one(ideal_pos_one),
    .pos_zero(nay_pos_zero), .pos_one(nay_pos_one),
    .cfg(cfg), .out_valid(nv), .util(un)
  );

  // merge lanes, scale by beta, prepare the link argument
  assign zprod = 51'(diff) * 51'($signed({1'b0, cfg.beta}));
  assign x35   = ax[34:0];
  assign big   = (ax[39:35] != 5'd0);
  assign sqp   = 70'(x35) * 70'(x35);
  assign pxp   = 65'(x35) * 65'(AS_P_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      k1v <= 1'b0;
      k2v <= 1'b0;
      k3v <= 1'b0;
    end else begin
      k1v <= yv && nv;
      k2v <= k1v;
      k3v <= k2v;
    end
    diff  <= 34'(uy) - 34'(un);
    neg2  <= zprod[50];
    ax    <= zprod[50] ? 40'((-zprod) >>> 8) : 40'(zprod >>> 8);
    ein   <= cfg.mode ? 40'(sqp[69:33]) : ax;
    side3 <= {neg2, big, pxp[64:32]};
  end

  svp_exp #(.XW(40), .SideW(35)) u_exp_link (
    .clk(clk), .rst(rst), .in_valid(k3v), .x(ein), .in_side(side3),
    .out_valid(ev), .y(e), .out_side(eside)
  );

  // divider feed: 1/(1+p*x) for the normal link, rounded ratio for logistic
  always_comb begin
    lnum = eside[34] ? {e, 16'h0000} : 49'h1_0000_0000_0000;
    lden = ONE_Q32 + 34'(e);
    if (cfg.mode) begin
      dnum = '1;
      dden = ONE_Q32 + 34'(eside[32:0]);
    end else begin
      dnum = 64'(lnum) + 64'(lden >> 1);
      dden = lden;
    end
    phip = 64'(e) * 64'(INV_SQRT2PI_Q32);
  end

  svp_div #(.SideW(34)) u_div (
    .clk(clk), .rst(rst), .in_valid(ev), .num(dnum), .den(dden),
    .in_side({eside[34], eside[33], phip[63:32]}),
    .out_valid(dv), .q(dq), .out_side(dside)
  );

  always_comb begin
    pa[0]   = AS_B5;
    pt[0]   = dq;
    pneg[0] = dside[33];
    pbig[0] = dside[32];
    pphi[0] = dside[31:0];
    pv[0]   = dv;
  end

  // Horner steps, one truncating product per stage
  for (genvar j = 0; j < 5; j++) begin : g_poly
    logic [35:0]        mag;
    logic [67:0]        prod;
    logic signed [36:0] sm;
    assign mag  = pa[j][36] ? 36'(-pa[j]) : pa[j][35:0];
    assign prod = 68'(mag) * 68'(pt[j]);
    assign sm   = pa[j][36] ? -37'(prod[67:32]) : 37'(prod[67:32]);
    always_ff @(posedge clk) begin
      if (rst) pv[j+1] <= 1'b0;
      else pv[j+1] <= pv[j];
      pa[j+1]   <= POLY_C[j] + sm;
      pt[j+1]   <= pt[j];
      pneg[j+1] <= pneg[j];
      pbig[j+1] <= pbig[j];
      pphi[j+1] <= pphi[j];
    end
  end

  assign accp  = pa[5][36] ? 36'd0 : pa[5][35:0];
  assign tprod = 67'(pphi[5]) * 67'(accp);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= pv[5];
    neg6 <= pneg[5];
    q6   <= pt[5];
    if (pbig[5]) tail <= 33'd0;
    else if (tprod[66:32] > 35'(ONE_Q32)) tail <= ONE_Q32[32:0];
    else tail <= tprod[64:32];
  end

  assign nval   = neg6 ? tail : 33'(ONE_Q32) - tail;
  assign nround = 18'((34'(nval) + 34'h8000) >> 16);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v6;
    if (cfg.mode) yea_probability <= (nround > 18'd65535) ? 16'hFFFF : nround[15:0];
    else yea_probability <= (q6 > 32'd65535) ? 16'hFFFF : q6[15:0];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/svp_check.sv =====
`default_nettype none
module svp_check import svp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_no_busy_after_reset: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy high outside reset");

  a_reset_clears_done: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, SVP_LAT))
    else $error("result without matching transaction");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##SVP_LAT done)
    else $error("transaction lost");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind spatial_vote_probability_unit svp_check u_check (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import svp_pkg::*;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    logic signed [15:0] ideal0, ideal1, yea0, yea1, nay0, nay1;
  } vote_pair_t;

  typedef struct {
    op_kind_t   kind;
    vote_pair_t pair;
    logic [7:0] idx;
    logic [15:0] data;
  } pending_op_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 104;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] ideal_pos_zero = '0, ideal_pos_one = '0;
  logic signed [15:0] yea_pos_zero = '0, yea_pos_one = '0;
  logic signed [15:0] nay_pos_zero = '0, nay_pos_one = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic [15:0] yea_probability;

  always #2 clk = ~clk;

  spatial_vote_probability_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ideal_pos_zero(ideal_pos_zero), .ideal_pos_one(ideal_pos_one),
    .yea_pos_zero(yea_pos_zero), .yea_pos_one(yea_pos_one),
    .nay_pos_zero(nay_pos_zero), .nay_pos_one(nay_pos_one),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .yea_probability(yea_probability)
  );

  pending_op_t pending[$];
  logic [15:0] expected_prob[$];
  cfg_regs_t   model_cfg;
  int          mismatches = 0;
  int          gap = 0;
  int          idle_cycles = 0;

  // ---------------- fixed-point vote model ----------------
  function automatic u64_t mul_hi32(u64_t a, u64_t b);
    return a * (b >> 32) + ((a * (b & 64'hFFFF_FFFF)) >> 32);
  endfunction

  function automatic s64_t smul_hi32(s64_t a, u64_t t);
    u64_t mag;
    u64_t p;
    mag = (a < 0) ? u64_t'(-a) : u64_t'(a);
    p = mul_hi32(t, mag);
    return (a < 0) ? -s64_t'(p) : s64_t'(p);
  endfunction

  function automatic u64_t exp_neg(u64_t x);
    u64_t n;
    u64_t r;
    u64_t term;
    s64_t sum;
    n = x / u64_t'(LN2_Q32);
    term = u64_t'(ONE_Q32);
    sum = s64_t'(ONE_Q32);
    if (n > 32) return 0;
    r = x - n * u64_t'(LN2_Q32);
    for (int k = 1; k <= 13; k++) begin
      term = ((term * r) >> 32) / u64_t'(k);
      if (k & 1) sum -= s64_t'(term);
      else sum += s64_t'(term);
    end
    if (sum < 0) sum = 0;
    return u64_t'(sum) >> n;
  endfunction

  function automatic u64_t sq_dist(vote_pair_t v, logic signed [15:0] p0,
                                   logic signed [15:0] p1);
    s64_t d0;
    s64_t d1;
    u64_t m0;
    u64_t m1;
    d0 = s64_t'(v.ideal0) - s64_t'(p0);
    d1 = s64_t'(v.ideal1) - s64_t'(p1);
    m0 = (d0 < 0) ? u64_t'(-d0) : u64_t'(d0);
    m1 = (d1 < 0) ? u64_t'(-d1) : u64_t'(d1);
    return m0 * m0 * u64_t'(model_cfg.w_zero) + m1 * m1 * u64_t'(model_cfg.w_one);
  endfunction

  function automatic u64_t normal_upper_tail(u64_t x);
    u64_t t;
    u64_t sq;
    u64_t phi;
    s64_t acc;
    if (x >= (u64_t'(8) << 32)) return 0;
    t = 64'hFFFF_FFFF_FFFF_FFFF / (u64_t'(ONE_Q32) + mul_hi32(u64_t'(AS_P_Q32), x));
    acc = s64_t'(AS_B5);
    acc = s64_t'(AS_B4) + smul_hi32(acc, t);
    acc = s64_t'(AS_B3) + smul_hi32(acc, t);
    acc = s64_t'(AS_B2) + smul_hi32(acc, t);
    acc = s64_t'(AS_B1) + smul_hi32(acc, t);
    acc = smul_hi32(acc, t);
    if (acc < 0) acc = 0;
    sq = (x >> 32) * x + mul_hi32(x & 64'hFFFF_FFFF, x);
    phi = mul_hi32(u64_t'(INV_SQRT2PI_Q32), exp_neg(sq >> 1));
    t = mul_hi32(phi, u64_t'(acc));
    return (t > u64_t'(ONE_Q32)) ? u64_t'(ONE_Q32) : t;
  endfunction

  function automatic logic [15:0] yea_prob_of(vote_pair_t v);
    u64_t uy;
    u64_t un;
    u64_t ax;
    u64_t p;
    u64_t e;
    u64_t den;
    u64_t num;
    s64_t z;
    logic neg;
    uy = exp_neg(sq_dist(v, v.yea0, v.yea1) >> 4);
    un = exp_neg(sq_dist(v, v.nay0, v.nay1) >> 4);
    z = (s64_t'(uy) - s64_t'(un)) * s64_t'(model_cfg.beta);
    neg = z < 0;
    ax = (neg ? u64_t'(-z) : u64_t'(z)) >> 8;
    if (model_cfg.mode) begin
      e = normal_upper_tail(ax);
      p = (neg ? e : u64_t'(ONE_Q32) - e);
      p = (p + 64'h8000) >> 16;
    end else begin
      e = exp_neg(ax);
      den = u64_t'(ONE_Q32) + e;
      num = neg ? (e << 16) : (u64_t'(1) << 48);
      p = (num + (den >> 1)) / den;
    end
    if (p > 65535) p = 65535;
    return p[15:0];
  endfunction

  function automatic void write_model_reg(logic [7:0] idx, logic [15:0] data);
    case (idx)
      REG_BETA:   model_cfg.beta = data;
      REG_W_ZERO: model_cfg.w_zero = data;
      REG_W_ONE:  model_cfg.w_one = data;
      REG_MODE:   model_cfg.mode = data[0];
      default: ;
    endcase
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4: return 16'sh0001;
      default: return 16'(signed'($urandom));
    endcase
  endfunction

  function automatic logic signed [15:0] near(logic signed [15:0] base, int spread);
    return base + 16'(signed'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic push_pair(logic signed [15:0] i0, i1, y0, y1, n0, n1);
    pending_op_t op;
    op.kind = OP_ITEM;
    op.pair = '{i0, i1, y0, y1, n0, n1};
    op.idx = '0;
    op.data = '0;
    pending.push_back(op);
  endtask

  task automatic push_reg(logic [7:0] idx, logic [15:0] data);
    pending_op_t op;
    op.kind = OP_CFG;
    op.pair = '{default: '0};
    op.idx = idx;
    op.data = data;
    pending.push_back(op);
  endtask

  task automatic push_drain();
    pending_op_t op;
    op.kind = OP_DRAIN;
    op.pair = '{default: '0};
    op.idx = '0;
    op.data = '0;
    pending.push_back(op);
  endtask

  task automatic push_random_pair();
    logic signed [15:0] i0, i1;
    int spread;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      spread = ($urandom_range(0, 2) == 0) ? 4096 : 512;
      i0 = near(16'sh0, 8192);
      i1 = near(16'sh0, 8192);
      push_pair(i0, i1, near(i0, spread), near(i1, spread),
                near(i0, spread), near(i1, spread));
    end else if (r < 90) begin
      push_pair(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
    end else begin
      push_pair(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                pick_extreme(), pick_extreme());
    end
  endtask

  task automatic push_settings(logic [15:0] beta, w0, w1, logic [15:0] mode);
    push_drain();
    push_reg(REG_BETA, beta);
    push_reg(REG_W_ZERO, w0);
    push_reg(REG_W_ONE, w1);
    push_reg(REG_MODE, mode);
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    logic nstart;
    logic ncfg;
    nstart = 1'b0;
    ncfg = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_prob.push_back(yea_prob_of(pending[0].pair));
        void'(pending.pop_front());
        gap = draw_gap();
      end
      if (cfg_valid && cfg_ready) begin
        write_model_reg(cfg_index, cfg_data);
        void'(pending.pop_front());
        gap = draw_gap();
      end
      if (pending.size() > 0 && pending[0].kind == OP_DRAIN &&
          expected_prob.size() == 0) begin
        void'(pending.pop_front());
        gap = 8;
      end
      if (gap > 0) begin
        gap--;
      end else if (pending.size() > 0) begin
        if (pending[0].kind == OP_ITEM) begin
          nstart = 1'b1;
          ideal_pos_zero <= pending[0].pair.ideal0;
          ideal_pos_one  <= pending[0].pair.ideal1;
          yea_pos_zero   <= pending[0].pair.yea0;
          yea_pos_one    <= pending[0].pair.yea1;
          nay_pos_zero   <= pending[0].pair.nay0;
          nay_pos_one    <= pending[0].pair.nay1;
        end else if (pending[0].kind == OP_CFG && expected_prob.size() == 0) begin
          ncfg = 1'b1;
          cfg_index <= pending[0].idx;
          cfg_data  <= pending[0].data;
        end
      end
    end
    start <= nstart;
    cfg_valid <= ncfg;
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && done) begin
      if (expected_prob.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: yea_probability=%0d", yea_probability);
      end else begin
        want = expected_prob.pop_front();
        if (yea_probability !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: yea_probability expected %0d actual %0d",
                     want, yea_probability);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    model_cfg = CFG_RESET;

    // directed: defaults first, then every register written
    push_pair(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_pair(16'sh1000, 16'shF000, 16'sh1000, 16'shF000, 16'sh7FFF, 16'sh7FFF);
    push_pair(16'sh1000, 16'shF000, 16'sh7FFF, 16'sh7FFF, 16'sh1000, 16'shF000);
    push_pair(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    push_pair(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    push_pair(16'sh0100, 16'sh0100, 16'sh0200, 16'sh0000, 16'sh0000, 16'sh0200);
    push_pair(16'sh0000, 16'sh0000, 16'sh0400, 16'sh0000, 16'sh0800, 16'sh0000);
    push_pair(16'sh0000, 16'sh0000, 16'sh0C00, 16'sh0000, 16'sh0400, 16'sh0000);
    push_pair(16'shFFFF, 16'shFFFF, 16'sh0001, 16'sh0001, 16'sh0000, 16'sh0000);
    push_settings(16'd65535, 16'd65535, 16'd65535, 16'd0);
    push_pair(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh2000, 16'sh0000);
    push_pair(16'sh0000, 16'sh0000, 16'sh2000, 16'sh0000, 16'sh0100, 16'sh0000);
    push_pair(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    push_pair(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_settings(16'd0, 16'd0, 16'd0, 16'd1);
    push_pair(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh2000, 16'sh0000);
    push_pair(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000);
    // out-of-range index ignored; mode keeps only its low bit
    push_drain();
    push_reg(8'd4, 16'hFFFF);
    push_reg(8'hFF, 16'h0000);
    push_reg(REG_BETA, 16'd65535);
    push_reg(REG_MODE, 16'hFFFE);
    push_pair(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh2000, 16'sh0000);
    push_pair(16'sh0000, 16'sh0000, 16'sh2000, 16'sh0000, 16'sh0100, 16'sh0000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: push_settings(16'd2048, 16'd4096, 16'd4096, 16'd1);
        1: push_settings(16'd2048, 16'd4096, 16'd4096, 16'd0);
        2: push_settings(16'd65535, 16'd65535, 16'd65535, 16'd1);
        3: push_settings(16'd1, 16'd0, 16'd65535, 16'd0);
        4: push_settings(16'd256, 16'd1, 16'd1, 16'd1);
        default: push_settings(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_random_pair();
        // hold off until the pipe empties now and then
        if ($urandom_range(0, 59) == 0) push_drain();
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || expected_prob.size() != 0) @(posedge clk);
    repeat (SVP_LAT + 20) @(posedge clk);
    if (mismatches == 0 && expected_prob.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/svp_pkg.sv
hw/rtl/svp_exp.sv
hw/rtl/svp_div.sv
hw/rtl/svp_lane.sv
hw/rtl/spatial_vote_probability_unit.sv
hw/rtl/svp_check.sv
test/tb_top.sv
